// ----- rtl/core/mst_pkg.sv -----
// Shared types and constants for the multi-slot alarm timer.
// Used by the slot cell and the top level; depends on nothing else.
package mst_pkg;

    // Operation codes carried in s_tuser.
    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_ARM    = 2'd1,
        FUNC_REMOVE = 2'd2
    } func_e;

    // Result kinds carried in m_tuser.
    typedef enum logic [2:0] {
        EV_ARMED    = 3'd0,
        EV_FULL     = 3'd1,
        EV_WAKE     = 3'd2,
        EV_CALLBACK = 3'd3,
        EV_REMOVED  = 3'd4
    } event_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_ARM,
        ST_FLUSH
    } state_e;

    // An upper payload byte of this value marks a task-wake alarm.
    localparam logic [7:0] WAKE_MARK = 8'hff;

    // Command lines broadcast from the controller to every cell.
    typedef struct packed {
        logic        step;
        logic        mode_tick;
        logic [7:0]  count;
        logic [15:0] id;
        logic        wr_en;
        logic [7:0]  expiry;
        logic [15:0] payload;
        logic        clr_en;
        logic [2:0]  clr_sel;
    } ctl_t;

    // Scan token and search flags handed from cell to cell.
    typedef struct packed {
        logic tok;
        logic mfound;
        logic ffound;
    } link_t;

    // Expiry report of the cell holding the token.
    typedef struct packed {
        logic        hit;
        logic        wake;
        logic [15:0] payload;
    } hit_t;

    // One result word.
    typedef struct packed {
        event_e      kind;
        logic [2:0]  idx;
        logic [15:0] payload;
        logic        last;
    } res_t;

endpackage

// ----- rtl/core/mst_cell.sv -----
// One alarm slot of the timer chain: stores the slot and passes the scan token on.
// Depends on mst_pkg.
module mst_cell #(
    parameter int IDX = 0,
    parameter int IW  = 3
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  mst_pkg::ctl_t   ctl,
    input  logic [IW-1:0]   wr_idx,
    input  mst_pkg::link_t  link_in,
    input  logic [IW-1:0]   midx_in,
    input  logic [IW-1:0]   fidx_in,
    output mst_pkg::link_t  link_out,
    output logic [IW-1:0]   midx_out,
    output logic [IW-1:0]   fidx_out,
    output mst_pkg::hit_t   hit
);
    import mst_pkg::*;

    logic          valid_reg, valid_next;
    logic [15:0]   owner_reg;
    logic [7:0]    expiry_reg;
    logic [15:0]   payload_reg;
    link_t         link_reg;
    logic [IW-1:0] midx_reg;
    logic [IW-1:0] fidx_reg;
    logic          match;
    logic          fire;
    logic          wake;
    logic          wr_here;

    assign match   = valid_reg && (owner_reg == ctl.id);
    assign wake    = (payload_reg[15:8] == WAKE_MARK);
    assign fire    = link_reg.tok && ctl.mode_tick && valid_reg && (expiry_reg == ctl.count);
    assign wr_here = ctl.wr_en && (wr_idx == IW'(IDX));

    // The first matching owner and the first free slot are recorded as the token passes.
    always_comb begin
        link_out = link_reg;
        midx_out = midx_reg;
        fidx_out = fidx_reg;
        if (link_reg.tok && !link_reg.mfound && match) begin
            link_out.mfound = 1'b1;
            midx_out        = IW'(IDX);
        end
        if (link_reg.tok && !link_reg.ffound && !valid_reg) begin
            link_out.ffound = 1'b1;
            fidx_out        = IW'(IDX);
        end
    end

    always_comb begin
        hit.hit     = fire;
        hit.wake    = fire && wake;
        hit.payload = fire ? payload_reg : 16'd0;
    end

    always_comb begin
        valid_next = valid_reg;
        priority if (wr_here) begin
            valid_next = 1'b1;
        end else if (ctl.clr_en && (int'(ctl.clr_sel) == IDX)) begin
            valid_next = 1'b0;
        end else if (ctl.step && fire && !wake) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            link_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            if (ctl.step) begin
                link_reg <= link_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.step) begin
            midx_reg <= midx_in;
            fidx_reg <= fidx_in;
        end
        if (wr_here) begin
            owner_reg   <= ctl.id;
            expiry_reg  <= ctl.expiry;
            payload_reg <= ctl.payload;
        end
    end

endmodule

// ----- rtl/core/multi_slot_alarm_timer.sv -----
// Multi-slot alarm timer: SLOTS alarm slots kept in a chain of cells, one slot per cell,
// driven by an 8-bit wrapping tick counter. A tick word advances the counter and sends a
// scan token down the chain, one cell per cycle while no due slot waits on a stalled output;
// each due slot reports a wake or callback word in slot order. An arm word sends the token
// down the chain to find the slot with the same timer id or else the lowest free slot. One
// word is worked on at a time; m_tlast marks the final result word of each input word.
// Depends on mst_pkg and mst_cell.
module multi_slot_alarm_timer #(
    parameter int SLOTS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // timer_id[15:0], delay_ticks[23:16], payload[39:24],
                                   // slot_select[42:40], zero fill
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // slot_index[2:0], event_payload[18:3], zero fill
    output logic [2:0]  m_tuser,   // event_kind[2:0]
    output logic        m_tlast    // last_result
);
    import mst_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    state_e        state_reg, state_next;
    logic [7:0]    count_reg, count_next;
    logic [15:0]   id_reg, id_next;
    logic [7:0]    expiry_reg, expiry_next;
    logic [15:0]   pay_reg, pay_next;
    logic [IW-1:0] pos_reg, pos_next;
    logic          pend_valid_reg, pend_valid_next;
    res_t          pend_reg, pend_next;
    logic          out_valid_reg, out_valid_next;
    res_t          out_reg, out_next;

    link_t         lnk  [SLOTS+1];
    logic [IW-1:0] midx [SLOTS+1];
    logic [IW-1:0] fidx [SLOTS+1];
    hit_t          hits [SLOTS];
    hit_t          hit_or;
    ctl_t          ctl;
    logic [IW-1:0] widx;

    func_e in_func;
    logic  accept;
    logic  start;
    logic  out_free;
    logic  adv_tick;
    logic  step;
    logic  done;
    logic  found;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_func  = func_e'(s_tuser);
    assign start    = accept && ((in_func == FUNC_TICK) || (in_func == FUNC_ARM));
    assign out_free = !out_valid_reg || m_tready;

    // A second due slot waits while the held word cannot move to the output register.
    assign adv_tick = !(hit_or.hit && pend_valid_reg && !out_free);
    assign step     = start || ((state_reg == ST_TICK) && adv_tick) || (state_reg == ST_ARM);
    assign done     = step && lnk[SLOTS].tok;
    assign found    = lnk[SLOTS].mfound || lnk[SLOTS].ffound;
    assign widx     = lnk[SLOTS].mfound ? midx[SLOTS] : fidx[SLOTS];

    always_comb begin
        lnk[0].tok    = start;
        lnk[0].mfound = 1'b0;
        lnk[0].ffound = 1'b0;
        midx[0]       = '0;
        fidx[0]       = '0;
    end

    always_comb begin
        ctl.step      = step;
        ctl.mode_tick = (state_reg == ST_TICK);
        ctl.count     = count_reg;
        ctl.id        = id_reg;
        ctl.wr_en     = (state_reg == ST_ARM) && done && found;
        ctl.expiry    = expiry_reg;
        ctl.payload   = pay_reg;
        ctl.clr_en    = accept && (in_func == FUNC_REMOVE);
        ctl.clr_sel   = s_tdata[42:40];
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        mst_cell #(
            .IDX (g),
            .IW  (IW)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .wr_idx   (widx),
            .link_in  (lnk[g]),
            .midx_in  (midx[g]),
            .fidx_in  (fidx[g]),
            .link_out (lnk[g+1]),
            .midx_out (midx[g+1]),
            .fidx_out (fidx[g+1]),
            .hit      (hits[g])
        );
    end

    // Only the cell holding the token can report, so the reports merge by OR.
    always_comb begin
        hit_or = '0;
        for (int i = 0; i < SLOTS; i++) begin
            hit_or = hit_t'(hit_or | hits[i]);
        end
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        id_next         = id_reg;
        expiry_next     = expiry_reg;
        pay_next        = pay_reg;
        pos_next        = pos_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_func)
                        FUNC_TICK: begin
                            count_next = count_reg + 8'd1;
                            pos_next   = '0;
                            state_next = ST_TICK;
                        end
                        FUNC_ARM: begin
                            id_next     = s_tdata[15:0];
                            expiry_next = count_reg + s_tdata[23:16];
                            pay_next    = s_tdata[39:24];
                            state_next  = ST_ARM;
                        end
                        FUNC_REMOVE: begin
                            pend_next.kind    = EV_REMOVED;
                            pend_next.idx     = s_tdata[42:40];
                            pend_next.payload = 16'd0;
                            pend_next.last    = 1'b1;
                            pend_valid_next   = 1'b1;
                            state_next        = ST_FLUSH;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_TICK: begin
                if (step) begin
                    pos_next = pos_reg + IW'(1);
                    if (hit_or.hit) begin
                        // The held word is not the last one, since another slot is due.
                        if (pend_valid_reg) begin
                            out_next       = pend_reg;
                            out_next.last  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        pend_next.kind    = hit_or.wake ? EV_WAKE : EV_CALLBACK;
                        pend_next.idx     = 3'(pos_reg);
                        pend_next.payload = hit_or.payload;
                        pend_next.last    = 1'b0;
                        pend_valid_next   = 1'b1;
                    end
                    if (done) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_ARM: begin
                if (done) begin
                    pend_next.kind    = found ? EV_ARMED : EV_FULL;
                    pend_next.idx     = found ? 3'(widx) : 3'd0;
                    pend_next.payload = 16'd0;
                    pend_next.last    = 1'b1;
                    pend_valid_next   = 1'b1;
                    state_next        = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= 8'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg     <= id_next;
        expiry_reg <= expiry_next;
        pay_reg    <= pay_next;
        pos_reg    <= pos_next;
        pend_reg   <= pend_next;
        out_reg    <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {5'd0, out_reg.payload, out_reg.idx};
    assign m_tlast  = out_reg.last;

endmodule

// ----- test/tb_top.sv -----
// Testbench for multi_slot_alarm_timer: tick, arm and remove words are driven on the input stream,
// and every result word is checked against a predictor of the slot table kept in a scoreboard class.
// Depends on mst_pkg and the multi_slot_alarm_timer RTL.
`timescale 1ns / 1ps

localparam int NUM_SLOTS = 8;

class alarm_scoreboard;
    logic [7:0]    tick_now;
    bit            slot_busy [NUM_SLOTS];
    logic [15:0]   slot_id   [NUM_SLOTS];
    logic [7:0]    slot_due  [NUM_SLOTS];
    logic [15:0]   slot_word [NUM_SLOTS];
    mst_pkg::res_t pending_events [$];
    int            mismatches;

    function new();
        tick_now   = '0;
        mismatches = 0;
        foreach (slot_busy[i]) begin
            slot_busy[i] = 1'b0;
            slot_id[i]   = '0;
            slot_due[i]  = '0;
            slot_word[i] = '0;
        end
    endfunction

    function void push_event(mst_pkg::event_e kind, logic [2:0] idx, logic [15:0] pay);
        mst_pkg::res_t ev;
        ev.kind    = kind;
        ev.idx     = idx;
        ev.payload = pay;
        ev.last    = 1'b0;
        pending_events.push_back(ev);
    endfunction

    // Updates the slot table for one accepted word and queues the results it causes.
    function void note_word(logic [1:0] func, logic [15:0] id, logic [7:0] delay,
                            logic [15:0] pay, logic [2:0] sel);
        int hit;
        int added;
        hit   = -1;
        added = 0;
        if (func == mst_pkg::FUNC_TICK) begin
            tick_now = tick_now + 8'd1;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (slot_busy[i] && slot_due[i] == tick_now) begin
                    if (slot_word[i][15:8] == mst_pkg::WAKE_MARK) begin
                        push_event(mst_pkg::EV_WAKE, i[2:0], slot_word[i]);
                    end else begin
                        push_event(mst_pkg::EV_CALLBACK, i[2:0], slot_word[i]);
                        slot_busy[i] = 1'b0;
                    end
                    added++;
                end
            end
        end else if (func == mst_pkg::FUNC_ARM) begin
            // A slot already owned by this id wins over the lowest free one.
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (hit < 0 && slot_busy[i] && slot_id[i] == id) hit = i;
            end
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (hit < 0 && !slot_busy[i]) hit = i;
            end
            if (hit < 0) begin
                push_event(mst_pkg::EV_FULL, 3'd0, 16'd0);
            end else begin
                slot_busy[hit] = 1'b1;
                slot_id[hit]   = id;
                slot_due[hit]  = tick_now + delay;
                slot_word[hit] = pay;
                push_event(mst_pkg::EV_ARMED, hit[2:0], 16'd0);
            end
            added = 1;
        end else if (func == mst_pkg::FUNC_REMOVE) begin
            slot_busy[sel] = 1'b0;
            push_event(mst_pkg::EV_REMOVED, sel, 16'd0);
            added = 1;
        end
        if (added > 0) pending_events[pending_events.size() - 1].last = 1'b1;
    endfunction

    task report_mismatch(string what);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    task check_result(logic [2:0] kind, logic [2:0] idx, logic [15:0] pay, logic last);
        mst_pkg::res_t want;
        if (pending_events.size() == 0) begin
            report_mismatch($sformatf("unexpected word kind %0d slot %0d payload %h",
                                      kind, idx, pay));
            return;
        end
        want = pending_events.pop_front();
        if (kind !== want.kind)
            report_mismatch($sformatf("event_kind got %0d want %0d", kind, want.kind));
        if (idx !== want.idx)
            report_mismatch($sformatf("slot_index got %0d want %0d", idx, want.idx));
        if (pay !== want.payload)
            report_mismatch($sformatf("event_payload got %h want %h", pay, want.payload));
        if (last !== want.last)
            report_mismatch($sformatf("last_result got %b want %b", last, want.last));
    endtask
endclass

module tb_top;
    import mst_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         HOLD_CYCLES = 300;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    alarm_scoreboard sb;
    int              words_sent;

    multi_slot_alarm_timer #(
        .SLOTS(NUM_SLOTS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Both sides stop idling over this span of accepted words.
    function automatic bit quiet_span();
        return words_sent >= 220 && words_sent < 290;
    endfunction

    task automatic send_word(logic [1:0] func, logic [15:0] id, logic [7:0] delay,
                             logic [15:0] pay, logic [2:0] sel);
        bit taken;
        taken = 1'b0;
        while (!quiet_span() && $urandom_range(0, 99) < 24) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {5'd0, sel, pay, delay, id};
        while (!taken) begin
            @(posedge aclk);
            if (s_tready) begin
                taken = 1'b1;
                sb.note_word(func, id, delay, pay, sel);
                words_sent++;
            end
            @(negedge aclk);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off that backs the block up.
    initial begin
        bit held;
        held     = 1'b0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (!held && words_sent >= 120) begin
                held = 1'b1;
                for (int c = 0; c < HOLD_CYCLES; c++) begin
                    m_tready <= 1'b0;
                    @(negedge aclk);
                end
            end else begin
                m_tready <= quiet_span() || $urandom_range(0, 99) >= 24;
                @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[2:0], m_tdata[18:3], m_tlast);
    end

    initial begin
        logic [15:0] id_pool [10];
        logic [1:0]  fn;
        logic [15:0] id;
        logic [7:0]  delay;
        logic [15:0] pay;
        logic [2:0]  sel;
        int          r;
        int          counted;
        int          ticks_sent;
        int          guard;

        sb         = new();
        words_sent = 0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed words.
        send_word(FUNC_TICK,   16'h0000, 8'd0,   16'h0000, 3'd0);  // nothing due
        send_word(FUNC_ARM,    16'hffff, 8'd0,   16'hff00, 3'd0);  // zero delay, wake alarm
        send_word(FUNC_ARM,    16'h0000, 8'd1,   16'h0000, 3'd0);
        send_word(FUNC_ARM,    16'h1234, 8'd255, 16'hffff, 3'd0);  // expiry wraps to zero
        send_word(FUNC_ARM,    16'h0000, 8'd2,   16'h00ff, 3'd0);  // same id reuses its slot
        send_word(FUNC_TICK,   16'h0000, 8'd0,   16'h0000, 3'd0);
        send_word(FUNC_TICK,   16'hffff, 8'hff,  16'hffff, 3'd7);  // callback fires
        send_word(FUNC_ARM,    16'ha5a5, 8'd1,   16'hfeff, 3'd0);
        send_word(FUNC_ARM,    16'h5a5a, 8'd1,   16'h0100, 3'd0);
        send_word(FUNC_ARM,    16'h0001, 8'd1,   16'hff7f, 3'd0);
        send_word(FUNC_ARM,    16'h8000, 8'd1,   16'h8001, 3'd0);
        send_word(FUNC_ARM,    16'h7fff, 8'd1,   16'hff80, 3'd0);
        send_word(FUNC_ARM,    16'h00f0, 8'd1,   16'h7ffe, 3'd0);
        send_word(FUNC_ARM,    16'h4242, 8'd9,   16'h1111, 3'd0);  // table full
        send_word(FUNC_ARM,    16'ha5a5, 8'd3,   16'hff12, 3'd0);  // reuse while full
        send_word(FUNC_TICK,   16'h0000, 8'd0,   16'h0000, 3'd0);  // several slots fire
        send_word(FUNC_REMOVE, 16'h0000, 8'd0,   16'h0000, 3'd7);  // slot already free
        send_word(FUNC_REMOVE, 16'h0000, 8'd0,   16'h0000, 3'd6);
        send_word(FUNC_UNUSED, 16'hffff, 8'hff,  16'hffff, 3'd7);  // ignored
        send_word(FUNC_UNUSED, 16'h0000, 8'd0,   16'h0000, 3'd0);
        send_word(FUNC_TICK,   16'h0000, 8'd0,   16'h0000, 3'd0);
        send_word(FUNC_TICK,   16'h0000, 8'd0,   16'h0000, 3'd0);  // wake slot stays armed
        send_word(FUNC_REMOVE, 16'h0000, 8'd0,   16'h0000, 3'd4);

        // Random words: mostly ticks so the counter wraps, with ids drawn from a small pool
        // so that arms often find their own slot again.
        foreach (id_pool[k]) id_pool[k] = 16'($urandom_range(0, 16'hfffe));
        counted    = 0;
        ticks_sent = 0;
        while (counted < 350) begin
            r  = $urandom_range(0, 99);
            fn = (r < 75) ? FUNC_TICK : (r < 90) ? FUNC_ARM : (r < 96) ? FUNC_REMOVE
                                                                     : FUNC_UNUSED;
            id    = ($urandom_range(0, 99) < 75) ? id_pool[$urandom_range(0, 9)]
                                                 : 16'($urandom);
            delay = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 12)) : 8'($urandom);
            pay   = ($urandom_range(0, 99) < 30) ? {WAKE_MARK, 8'($urandom)} : 16'($urandom);
            // Slot 0 keeps its zero-delay alarm until the counter has come round again.
            sel   = (ticks_sent < 256) ? 3'($urandom_range(1, 7)) : 3'($urandom);
            if (fn != FUNC_UNUSED) counted++;
            if (fn == FUNC_TICK) ticks_sent++;
            send_word(fn, id, delay, pay, sel);
        end
        s_tvalid <= 1'b0;

        guard = 0;
        while (sb.pending_events.size() != 0 && guard < 50000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (NUM_SLOTS + 20) @(posedge aclk);
        if (sb.pending_events.size() != 0)
            sb.report_mismatch($sformatf("%0d expected words never arrived",
                                         sb.pending_events.size()));
        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
